### hw/rtl/lbpx_pkg.sv
`timescale 1ns / 1ps
package lbpx_pkg;
  localparam int MaxFrames = 16384;
  localparam int SampleBits = 24;
  localparam int GainBits = 16;
  localparam int PosBits = $clog2(MaxFrames);
  localparam int LenBits = PosBits + 1;
  localparam int AddrBits = PosBits + 2;
  localparam int QBits = 2 * GainBits + 1;

  typedef enum logic [1:0] {
    MODE_PULL = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_COMMIT = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [SampleBits-1:0] sample_in;
    logic load_last;
    logic filter_only;
  } in_beat_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_out;
    logic [PosBits-1:0] play_position;
    logic ready_res;
    logic commit_waiting;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic rd_new;
    logic rd_old;
    logic div_start;
    logic sqrt_start;
    logic mix;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fading;
    logic div_done;
    logic sqrt_done;
  } sts_t;
endpackage

### hw/rtl/lbpx_ram.sv
`timescale 1ns / 1ps
module lbpx_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/lbpx_ctrl.sv
`timescale 1ns / 1ps
module lbpx_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_go,
  input  logic is_pull,
  input  logic out_taken,
  input  lbpx_pkg::sts_t sts,
  output lbpx_pkg::cmd_t cmd,
  output logic busy,
  output logic out_valid
);
  typedef enum logic [2:0] {
    S_IDLE, S_RDNEW, S_RDOLD, S_DIV, S_SQRT, S_MIX, S_OUT
  } state_t;
  state_t state;

  always_comb begin
    cmd = '0;
    cmd.start = in_go;
    cmd.rd_new = (state == S_RDNEW);
    cmd.rd_old = (state == S_RDOLD);
    cmd.div_start = (state == S_RDOLD) && sts.fading;
    cmd.sqrt_start = (state == S_DIV) && sts.div_done;
    cmd.mix = (state == S_MIX);
    cmd.finish = (state == S_RDOLD) && !sts.fading || cmd.mix;
  end
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_go) begin
            if (is_pull) begin
              state <= S_RDNEW;
            end else begin
              state <= S_OUT;
              out_valid <= 1'b1;
            end
          end
        end
        S_RDNEW: state <= S_RDOLD;
        S_RDOLD: begin
          if (sts.fading) begin
            state <= S_DIV;
          end else begin
            state <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_DIV: if (sts.div_done) state <= S_SQRT;
        S_SQRT: if (sts.sqrt_done) state <= S_MIX;
        S_MIX: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (out_taken) begin
            state <= S_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hw/rtl/lbpx_dp.sv
`timescale 1ns / 1ps
module lbpx_dp (
  input  logic clk,
  input  logic rst,
  input  lbpx_pkg::cmd_t cmd,
  input  lbpx_pkg::in_beat_t in_beat,
  input  logic [14:0] fade_length,
  output lbpx_pkg::sts_t sts,
  output lbpx_pkg::out_beat_t out_beat
);
  localparam int PB = lbpx_pkg::PosBits;
  localparam int LB = lbpx_pkg::LenBits;
  localparam int AB = lbpx_pkg::AddrBits;
  localparam int SB = lbpx_pkg::SampleBits;
  localparam int GB = lbpx_pkg::GainBits;
  localparam int QB = lbpx_pkg::QBits;
  localparam int DB = 2 * GB + LB;
  localparam int SqB = GB + 1;
  localparam logic [LB-1:0] MaxLen = LB'(lbpx_pkg::MaxFrames);

  logic [1:0] pub_slot, pend_slot, fd_slot;
  logic [LB-1:0] slot_len [3];
  logic pub_valid, pend_complete;
  logic [LB-1:0] load_ptr;
  logic [PB-1:0] rd_ptr, pos;
  logic [14:0] fade_rem;
  logic fading, div_done, sqrt_done;

  logic we;
  logic [AB-1:0] waddr, raddr;
  logic [SB-1:0] wdata, rdata;
  logic signed [SB-1:0] new_s, old_s;

  lbpx_ram #(.Width(SB), .Depth(3 * lbpx_pkg::MaxFrames)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AB-1:0] addr_of(input logic [1:0] s, input logic [PB-1:0] p);
    logic [AB-1:0] base;
    base = AB'(s) * AB'(lbpx_pkg::MaxFrames);
    return base + AB'(p);
  endfunction

  logic [1:0] load_slot;
  logic [LB-1:0] load_idx;
  assign load_slot = (pend_slot < 2'd3) ? pend_slot : 2'd0;
  assign load_idx = pend_complete ? '0 : load_ptr;
  assign we = cmd.start && (in_beat.mode == lbpx_pkg::MODE_LOAD) && (load_idx < MaxLen);
  assign waddr = addr_of(load_slot, load_idx[PB-1:0]);
  assign wdata = in_beat.sample_in;

  logic [1:0] ps, fs;
  logic [LB-1:0] plen;
  assign ps = (pub_slot < 2'd3) ? pub_slot : 2'd0;
  assign fs = (fd_slot < 2'd3) ? fd_slot : 2'd0;
  assign plen = slot_len[ps];
  assign pos = (LB'(rd_ptr) < plen) ? rd_ptr : '0;
  assign raddr = addr_of(cmd.rd_new ? fs : ps, pos);

  logic play_ok;
  assign play_ok = pub_valid && (plen != '0) && (plen <= MaxLen);
  assign fading = play_ok && (fade_rem != '0) && (LB'(pos) < slot_len[fs]);
  assign sts = lbpx_pkg::sts_t'({fading, div_done, sqrt_done});

  logic [14:0] eff_len, r;
  assign eff_len = (fade_length == '0) ? 15'd1 : fade_length;
  assign r = (fade_rem > eff_len) ? eff_len : fade_rem;

  logic [DB-1:0] rem_acc;
  logic [QB-1:0] quo;
  logic [5:0] dcnt;
  logic div_run;
  logic [DB-1:0] dtrial;
  assign dtrial = {rem_acc[DB-2:0], quo[QB-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        div_run <= 1'b1;
        rem_acc <= DB'(r >> 1);
        quo <= {r[0], {(QB - 1){1'b0}}};
        dcnt <= 6'(QB);
      end else if (div_run) begin
        if (dtrial >= DB'(eff_len)) begin
          rem_acc <= dtrial - DB'(eff_len);
          quo <= {quo[QB-2:0], 1'b1};
        end else begin
          rem_acc <= dtrial;
          quo <= {quo[QB-2:0], 1'b0};
        end
        dcnt <= dcnt - 6'd1;
        if (dcnt == 6'd1) begin
          div_run <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  logic [QB:0] xa, xb;
  logic [QB-1:0] one_q;
  logic [QB+1:0] ra, rb;
  logic [SqB:0] qa, qb;
  logic [4:0] scnt;
  logic sq_run;
  logic [QB+1:0] ta, tb;
  assign one_q = QB'(1) << (2 * GB);
  assign ta = {ra[QB-1:0], xa[QB:QB-1]} - {{(QB - SqB - 1){1'b0}}, qa, 2'b01};
  assign tb = {rb[QB-1:0], xb[QB:QB-1]} - {{(QB - SqB - 1){1'b0}}, qb, 2'b01};
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_run <= 1'b0;
      sqrt_done <= 1'b0;
    end else begin
      sqrt_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_run <= 1'b1;
        xa <= {1'b0, quo};
        xb <= {1'b0, one_q - quo};
        ra <= '0;
        rb <= '0;
        qa <= '0;
        qb <= '0;
        scnt <= 5'(QB / 2 + 1);
      end else if (sq_run) begin
        xa <= xa << 2;
        xb <= xb << 2;
        if (!ta[QB+1]) begin
          ra <= ta;
          qa <= {qa[SqB-1:0], 1'b1};
        end else begin
          ra <= {ra[QB-1:0], xa[QB:QB-1]};
          qa <= {qa[SqB-1:0], 1'b0};
        end
        if (!tb[QB+1]) begin
          rb <= tb;
          qb <= {qb[SqB-1:0], 1'b1};
        end else begin
          rb <= {rb[QB-1:0], xb[QB:QB-1]};
          qb <= {qb[SqB-1:0], 1'b0};
        end
        scnt <= scnt - 5'd1;
        if (scnt == 5'd1) begin
          sq_run <= 1'b0;
          sqrt_done <= 1'b1;
        end
      end
    end
  end

  localparam int PrB = SB + SqB + 1;
  logic signed [PrB-1:0] pa, pb;
  logic signed [PrB:0] v;
  logic [PrB:0] mag, rq;
  logic signed [PrB:0] res;
  logic signed [SB-1:0] mixed;
  localparam logic signed [PrB:0] Hi = (PrB + 1)'((1 << (SB - 1)) - 1);
  assign pa = PrB'(old_s) * $signed({1'b0, qa[SqB-1:0]});
  assign pb = PrB'(new_s) * $signed({1'b0, qb[SqB-1:0]});
  assign v = (PrB + 1)'(pa) + (PrB + 1)'(pb);
  assign mag = v[PrB] ? (PrB + 1)'(-v) : (PrB + 1)'(v);
  assign rq = (mag + (PrB + 1)'(1 << (GB - 1))) >> GB;
  assign res = v[PrB] ? -$signed(rq) : $signed(rq);
  assign mixed = (res > Hi) ? SB'(Hi) : (res < -Hi - 1) ? SB'(-Hi - 1) : SB'(res);

  logic [LB-1:0] nlen, pos1;
  logic [1:0] np, op, of;
  assign np = load_slot;
  assign op = ps;
  assign of = fs;
  assign nlen = (slot_len[np] == '0) ? LB'(1) : slot_len[np];
  assign pos1 = LB'(pos) + LB'(1);

  always_ff @(posedge clk) begin
    if (cmd.rd_new) new_s <= rdata;
  end
  always_ff @(posedge clk) begin
    if (cmd.rd_old) old_s <= rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pub_slot <= 2'd0;
      pend_slot <= 2'd1;
      fd_slot <= 2'd2;
      slot_len <= '{default: '0};
      pub_valid <= 1'b0;
      pend_complete <= 1'b0;
      load_ptr <= '0;
      rd_ptr <= '0;
      fade_rem <= '0;
      out_beat <= '0;
    end else begin
      if (cmd.start) begin
        out_beat.sample_out <= '0;
        unique case (lbpx_pkg::mode_t'(in_beat.mode))
          lbpx_pkg::MODE_LOAD: begin
            if (in_beat.load_last) begin
              slot_len[load_slot] <= (load_idx < MaxLen) ? load_idx + LB'(1) : load_idx;
              pend_complete <= 1'b1;
              load_ptr <= '0;
              out_beat.commit_waiting <= 1'b1;
            end else begin
              pend_complete <= 1'b0;
              load_ptr <= (load_idx < MaxLen) ? load_idx + LB'(1) : load_idx;
              out_beat.commit_waiting <= 1'b0;
            end
            out_beat.play_position <= rd_ptr;
            out_beat.ready_res <= pub_valid;
          end
          lbpx_pkg::MODE_COMMIT: begin
            if (pend_complete) begin
              if (in_beat.filter_only) begin
                if (LB'(rd_ptr) > nlen - LB'(1)) rd_ptr <= PB'(nlen - LB'(1));
                if (pub_valid) begin
                  fd_slot <= op;
                  fade_rem <= (LB'(eff_len) < nlen) ? eff_len : 15'(nlen);
                  pend_slot <= of;
                end else begin
                  pend_slot <= op;
                end
                out_beat.play_position <=
                  (LB'(rd_ptr) > nlen - LB'(1)) ? PB'(nlen - LB'(1)) : rd_ptr;
              end else begin
                rd_ptr <= '0;
                pend_slot <= op;
                out_beat.play_position <= '0;
              end
              pub_slot <= np;
              pub_valid <= 1'b1;
              pend_complete <= 1'b0;
              load_ptr <= '0;
              out_beat.ready_res <= 1'b1;
              out_beat.commit_waiting <= 1'b0;
            end else begin
              out_beat.play_position <= rd_ptr;
              out_beat.ready_res <= pub_valid;
              out_beat.commit_waiting <= pend_complete;
            end
          end
          default: begin
            out_beat.play_position <= rd_ptr;
            out_beat.ready_res <= pub_valid;
            out_beat.commit_waiting <= pend_complete;
          end
        endcase
      end
      if (cmd.finish) begin
        if (play_ok) begin
          out_beat.sample_out <= cmd.mix ? mixed : new_s;
          rd_ptr <= (pos1 >= plen) ? '0 : PB'(pos1);
          out_beat.play_position <= (pos1 >= plen) ? '0 : PB'(pos1);
          if (cmd.mix) fade_rem <= fade_rem - 15'd1;
        end else begin
          out_beat.sample_out <= '0;
          out_beat.play_position <= rd_ptr;
        end
      end
    end
  end
endmodule

### hw/rtl/looped_buffer_player_crossfade.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake        Payload
// in       input      valid / stall    lbpx_pkg::in_beat_t
// out      output     valid / stall    lbpx_pkg::out_beat_t
// cfg      input      APB write/read   fade_length at address 0
// A load or commit beat goes from idle straight to the output state; a pull beat reads
// the new and old samples first and, during a fade, then runs the 33-step bit-serial
// divider and the 17-step bit-serial square root units before the mix.
// Reset is synchronous; the sample memory holds no reset and needs no clearing pass.
// One beat is worked at a time; out stall holds the result and the input.
module looped_buffer_player_crossfade (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  lbpx_pkg::in_beat_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output lbpx_pkg::out_beat_t out_data,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [14:0] fade_length;
  logic busy, in_go;
  lbpx_pkg::cmd_t cmd;
  lbpx_pkg::sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {17'd0, fade_length} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_length <= 15'd240;
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      fade_length <= pwdata[14:0];
    end
  end

  assign in_stall = busy;
  assign in_go = in_valid && !busy;

  lbpx_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_go(in_go),
    .is_pull(in_data.mode == lbpx_pkg::MODE_PULL),
    .out_taken(!out_stall), .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_valid)
  );

  lbpx_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_beat(in_data), .fade_length(fade_length),
    .sts(sts), .out_beat(out_data)
  );
endmodule
